### sv/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types, constants and the control store for the level tracker.
// ----------------------------------------------------------------------------
package slt_pkg;

	// number formats
	localparam int FRAC_BITS = 8;
	localparam int SAMPLE_W  = 16;
	localparam int TIME_W    = 16;
	localparam int VAL_W     = 15;
	localparam int PCT_W     = 7;
	localparam int IVL_W     = 32;
	localparam int SUM_W     = 40;
	localparam int QUO_W     = 16;
	localparam int REC_W     = 2;

	localparam logic [VAL_W-1:0] LEVEL_MAX = VAL_W'(100 << FRAC_BITS);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOWER_OFFSET   = 3'd0,
		REG_UPPER_OFFSET   = 3'd1,
		REG_REWARD_PERCENT = 3'd2,
		REG_MAX_RATE       = 3'd3,
		REG_CHECK_INTERVAL = 3'd4,
		REG_AUTO_RECAL     = 3'd5
	} cfg_idx_t;

	// configuration reset values
	localparam logic [VAL_W-1:0] RST_LOWER_OFFSET   = 15'd2560;
	localparam logic [VAL_W-1:0] RST_UPPER_OFFSET   = 15'd2560;
	localparam logic [PCT_W-1:0] RST_REWARD_PERCENT = 7'd50;
	localparam logic [VAL_W-1:0] RST_MAX_RATE       = 15'd2560;
	localparam logic [IVL_W-1:0] RST_CHECK_INTERVAL = 32'd3932160;

	// recalibration event codes
	localparam logic [REC_W-1:0] RECAL_NONE   = 2'd0;
	localparam logic [REC_W-1:0] RECAL_LOWER  = 2'd1;
	localparam logic [REC_W-1:0] RECAL_RAISE  = 2'd2;

	// shared multiplier and reciprocal constants
	localparam int MUL_W  = 23;
	localparam int PROD_W = 2 * MUL_W;
	localparam logic [MUL_W-1:0] RECIP10  = 23'd52429;   // 2^19 / 10, rounded up
	localparam int               REC10_SH = 19;
	localparam logic [MUL_W-1:0] RECIP100 = 23'd5368710; // 2^29 / 100, rounded up
	localparam int               REC100_SH = 29;
	localparam int               TIME_SH  = 16;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NOP,
		OP_ACCUM,
		OP_TIME,
		OP_CHECK,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_RECAL,
		OP_RATE_DIFF,
		OP_RATE_MUL,
		OP_RATE_CLAMP,
		OP_LEVEL_MUL,
		OP_LEVEL_UPD,
		OP_BASE_DIST,
		OP_BASE_MUL,
		OP_BASE_DIV,
		OP_BASE_UPD,
		OP_BOUNDS,
		OP_WIDTH,
		OP_PCT_MUL,
		OP_PCT_DIV,
		OP_THRESH,
		OP_EMIT
	} dp_op_t;

	// sequencer branch conditions
	typedef enum logic [1:0] {
		C_NEXT,
		C_JMP_NO_AVG,
		C_JMP_DIV_MORE,
		C_HOLD_OUT
	} cond_t;

	typedef logic [4:0] step_t;

	localparam step_t ST_ACCUM      = 5'd0;
	localparam step_t ST_TIME       = 5'd1;
	localparam step_t ST_CHECK      = 5'd2;
	localparam step_t ST_DIV_INIT   = 5'd3;
	localparam step_t ST_DIV_STEP   = 5'd4;
	localparam step_t ST_RECAL      = 5'd5;
	localparam step_t ST_RATE_DIFF  = 5'd6;
	localparam step_t ST_RATE_MUL   = 5'd7;
	localparam step_t ST_RATE_CLAMP = 5'd8;
	localparam step_t ST_LEVEL_MUL  = 5'd9;
	localparam step_t ST_LEVEL_UPD  = 5'd10;
	localparam step_t ST_BASE_DIST  = 5'd11;
	localparam step_t ST_BASE_MUL   = 5'd12;
	localparam step_t ST_BASE_DIV   = 5'd13;
	localparam step_t ST_BASE_UPD   = 5'd14;
	localparam step_t ST_BOUNDS     = 5'd15;
	localparam step_t ST_WIDTH      = 5'd16;
	localparam step_t ST_PCT_MUL    = 5'd17;
	localparam step_t ST_PCT_DIV    = 5'd18;
	localparam step_t ST_THRESH     = 5'd19;
	localparam step_t ST_EMIT       = 5'd20;

	typedef struct packed {
		dp_op_t op;
		cond_t  cond;
		step_t  target;
		logic   last;
	} ctrl_word_t;

	// sequencer to datapath
	typedef struct packed {
		dp_op_t op;
		logic   fire;
		logic   load;
	} seq_ctl_t;

	// datapath to sequencer
	typedef struct packed {
		logic avg_due;
		logic div_last;
		logic out_free;
	} dp_stat_t;

	// configuration write
	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// control store
	function automatic ctrl_word_t ucode_rom(input step_t step);
		ctrl_word_t cw;
		cw = '{op: OP_NOP, cond: C_NEXT, target: ST_ACCUM, last: 1'b1};
		case (step)
			ST_ACCUM:      cw = '{OP_ACCUM,      C_NEXT,         ST_ACCUM,     1'b0};
			ST_TIME:       cw = '{OP_TIME,       C_NEXT,         ST_ACCUM,     1'b0};
			ST_CHECK:      cw = '{OP_CHECK,      C_NEXT,         ST_ACCUM,     1'b0};
			ST_DIV_INIT:   cw = '{OP_DIV_INIT,   C_JMP_NO_AVG,   ST_RATE_DIFF, 1'b0};
			ST_DIV_STEP:   cw = '{OP_DIV_STEP,   C_JMP_DIV_MORE, ST_DIV_STEP,  1'b0};
			ST_RECAL:      cw = '{OP_RECAL,      C_NEXT,         ST_ACCUM,     1'b0};
			ST_RATE_DIFF:  cw = '{OP_RATE_DIFF,  C_NEXT,         ST_ACCUM,     1'b0};
			ST_RATE_MUL:   cw = '{OP_RATE_MUL,   C_NEXT,         ST_ACCUM,     1'b0};
			ST_RATE_CLAMP: cw = '{OP_RATE_CLAMP, C_NEXT,         ST_ACCUM,     1'b0};
			ST_LEVEL_MUL:  cw = '{OP_LEVEL_MUL,  C_NEXT,         ST_ACCUM,     1'b0};
			ST_LEVEL_UPD:  cw = '{OP_LEVEL_UPD,  C_NEXT,         ST_ACCUM,     1'b0};
			ST_BASE_DIST:  cw = '{OP_BASE_DIST,  C_NEXT,         ST_ACCUM,     1'b0};
			ST_BASE_MUL:   cw = '{OP_BASE_MUL,   C_NEXT,         ST_ACCUM,     1'b0};
			ST_BASE_DIV:   cw = '{OP_BASE_DIV,   C_NEXT,         ST_ACCUM,     1'b0};
			ST_BASE_UPD:   cw = '{OP_BASE_UPD,   C_NEXT,         ST_ACCUM,     1'b0};
			ST_BOUNDS:     cw = '{OP_BOUNDS,     C_NEXT,         ST_ACCUM,     1'b0};
			ST_WIDTH:      cw = '{OP_WIDTH,      C_NEXT,         ST_ACCUM,     1'b0};
			ST_PCT_MUL:    cw = '{OP_PCT_MUL,    C_NEXT,         ST_ACCUM,     1'b0};
			ST_PCT_DIV:    cw = '{OP_PCT_DIV,    C_NEXT,         ST_ACCUM,     1'b0};
			ST_THRESH:     cw = '{OP_THRESH,     C_NEXT,         ST_ACCUM,     1'b0};
			ST_EMIT:       cw = '{OP_EMIT,       C_HOLD_OUT,     ST_ACCUM,     1'b1};
			default:       cw = '{OP_NOP,        C_NEXT,         ST_ACCUM,     1'b1};
		endcase
		return cw;
	endfunction

endpackage

### sv/slt_in_if.sv
// ----------------------------------------------------------------------------
// slt_in_if
// Sample channel: band-power sample, elapsed time and session flag.
// ----------------------------------------------------------------------------
interface slt_in_if;
	import slt_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic [TIME_W-1:0]   elapsed;
	logic                session_active;

	modport source (output valid, output sample, output elapsed, output session_active,
		input ready);
	modport sink (input valid, input sample, input elapsed, input session_active,
		output ready);
endinterface

### sv/slt_out_if.sv
// ----------------------------------------------------------------------------
// slt_out_if
// Result channel: level, window bounds, baseline, reward and event.
// ----------------------------------------------------------------------------
interface slt_out_if;
	import slt_pkg::*;

	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] level;
	logic [VAL_W-1:0] lower_bound;
	logic [VAL_W-1:0] upper_bound;
	logic [VAL_W-1:0] baseline;
	logic             reward;
	logic [REC_W-1:0] recalibration;

	modport source (output valid, output level, output lower_bound, output upper_bound,
		output baseline, output reward, output recalibration, input ready);
	modport sink (input valid, input level, input lower_bound, input upper_bound,
		input baseline, input reward, input recalibration, output ready);
endinterface

### sv/slt_cfg_if.sv
// ----------------------------------------------------------------------------
// slt_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface slt_cfg_if;
	import slt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### sv/slt_mul.sv
// ----------------------------------------------------------------------------
// slt_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module slt_mul (
	input  logic                        clk,
	input  logic                        en,
	input  logic [slt_pkg::MUL_W-1:0]   a,
	input  logic [slt_pkg::MUL_W-1:0]   b,
	output logic [slt_pkg::PROD_W-1:0]  prod_q
);
	import slt_pkg::*;

	// product register, loaded only on a multiply step
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end
endmodule

### sv/slt_useq.sv
// ----------------------------------------------------------------------------
// slt_useq
// Microcode sequencer: step counter, control store and branch logic.
// ----------------------------------------------------------------------------
module slt_useq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  slt_pkg::dp_stat_t  stat,
	output slt_pkg::seq_ctl_t  ctl
);
	import slt_pkg::*;

	logic       run_q;
	step_t      pc_q;
	ctrl_word_t cw;
	logic       hold;
	logic       jump;
	logic       accept;

	// control word fetch and branch decode
	always_comb begin
		cw = ucode_rom(pc_q);
		hold = 1'b0;
		jump = 1'b0;
		case (cw.cond)
			C_NEXT:         jump = 1'b0;
			C_JMP_NO_AVG:   jump = !stat.avg_due;
			C_JMP_DIV_MORE: jump = !stat.div_last;
			C_HOLD_OUT:     hold = !stat.out_free;
			default:        jump = 1'b0;
		endcase
		item_ready = !run_q;
		accept = item_valid && !run_q;
		ctl.op = cw.op;
		ctl.fire = run_q && !hold;
		ctl.load = accept;
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			pc_q <= ST_ACCUM;
		end else if (accept) begin
			run_q <= 1'b1;
			pc_q <= ST_ACCUM;
		end else if (run_q && !hold) begin
			if (cw.last) begin
				run_q <= 1'b0;
				pc_q <= ST_ACCUM;
			end else if (jump) begin
				pc_q <= cw.target;
			end else begin
				pc_q <= pc_q + step_t'(1);
			end
		end
	end

	// program stays inside the control store
	assert property (@(posedge clk) disable iff (!arst_n) run_q |-> pc_q <= ST_EMIT)
		else $error("step counter left the program");

	// a transfer starts the program at its first step
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> run_q && pc_q == ST_ACCUM)
		else $error("program did not start after a transfer");

	// the last step returns to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && !hold && cw.last) |=> !run_q)
		else $error("sequencer did not stop after the last step");
endmodule

### sv/slt_dp.sv
// ----------------------------------------------------------------------------
// slt_dp
// Datapath: configuration, tracker state, divider and output register.
// ----------------------------------------------------------------------------
module slt_dp #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slt_pkg::seq_ctl_t             ctl,
	output slt_pkg::dp_stat_t             stat,
	input  slt_pkg::cfg_wr_t              cfg_wr,
	input  logic [slt_pkg::SAMPLE_W-1:0]  sample,
	input  logic [slt_pkg::TIME_W-1:0]    elapsed,
	input  logic                          session_active,
	slt_out_if.source                     results
);
	import slt_pkg::*;

	localparam int HI_W = SUM_W - QUO_W;
	localparam int RW   = ((COUNT_WIDTH > HI_W) ? COUNT_WIDTH : HI_W) + 1;

	// configuration
	logic [VAL_W-1:0] lo_off_q, up_off_q, max_rate_q;
	logic [PCT_W-1:0] pct_q;
	logic [IVL_W-1:0] chk_int_q;
	logic             auto_q;

	// tracker state
	logic [VAL_W-1:0]       level_q, base_q, target_q, rmag_q;
	logic                   rneg_q;
	logic [IVL_W-1:0]       tsc_q;
	logic [SUM_W-1:0]       sum_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	// per-item scratch
	logic [SAMPLE_W-1:0] sample_q;
	logic [TIME_W-1:0]   elapsed_q;
	logic                session_q;
	logic                avg_due_q;
	logic [REC_W-1:0]    event_q;
	logic [RW-1:0]       rem_q;
	logic [QUO_W-1:0]    dq_q;
	logic [3:0]          div_cnt_q;
	logic [15:0]         mag_q;
	logic                sgn_q, zero_q;
	logic [VAL_W-1:0]    lower_q, upper_q;
	logic                reward_q;

	// output register
	logic             out_valid_q;
	logic [VAL_W-1:0] o_level_q, o_lower_q, o_upper_q, o_base_q;
	logic             o_reward_q;
	logic [REC_W-1:0] o_event_q;

	// multiplier interface
	logic              mul_en;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod_q;

	// combinational helpers
	logic [SUM_W:0]         sum_add;
	logic                   acc_ok;
	logic [IVL_W:0]         t_add;
	logic                   expired;
	logic [RW-1:0]          div_sh, cnt_ext;
	logic                   div_ge;
	logic [QUO_W-1:0]       avg;
	logic [QUO_W:0]         avg_lo, base_up, mid;
	logic [VAL_W-1:0]       mid_cap;
	logic [15:0]            rate_mag_new;
	logic                   rate_neg_new;
	logic [VAL_W-1:0]       rate_clamped;
	logic [VAL_W-1:0]       lvl_d;
	logic [VAL_W:0]         lvl_up;
	logic [11:0]            base_d;
	logic [VAL_W:0]         lw, uw;
	logic [15:0]            qq;
	logic signed [17:0]     thr;

	slt_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// operand selection for the shared multiplier
	always_comb begin
		mul_en = 1'b0;
		mul_a = '0;
		mul_b = '0;
		case (ctl.op)
			OP_RATE_MUL: begin
				mul_en = ctl.fire;
				mul_a = MUL_W'(mag_q);
				mul_b = RECIP10;
			end
			OP_LEVEL_MUL: begin
				mul_en = ctl.fire;
				mul_a = MUL_W'(rmag_q);
				mul_b = MUL_W'(elapsed_q);
			end
			OP_BASE_MUL: begin
				mul_en = ctl.fire;
				mul_a = MUL_W'(mag_q);
				mul_b = MUL_W'(elapsed_q);
			end
			OP_BASE_DIV: begin
				mul_en = ctl.fire;
				mul_a = MUL_W'(prod_q[TIME_SH +: VAL_W]);
				mul_b = RECIP10;
			end
			OP_PCT_MUL: begin
				mul_en = ctl.fire;
				mul_a = MUL_W'(mag_q);
				mul_b = MUL_W'(pct_q);
			end
			OP_PCT_DIV: begin
				mul_en = ctl.fire;
				mul_a = MUL_W'(prod_q[21:0]);
				mul_b = RECIP100;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// arithmetic shared by the steps
	always_comb begin
		sum_add = {1'b0, sum_q} + (SUM_W + 1)'(sample_q);
		acc_ok = (cnt_q != '1) && !sum_add[SUM_W];
		t_add = {1'b0, tsc_q} + (IVL_W + 1)'(elapsed_q);
		expired = tsc_q > chk_int_q;
		cnt_ext = RW'(cnt_q);
		div_sh = {rem_q[RW-2:0], dq_q[QUO_W-1]};
		div_ge = div_sh >= cnt_ext;
		avg = (cnt_q == '0) ? '0 : dq_q;
		avg_lo = {1'b0, avg} + (QUO_W + 1)'(lo_off_q);
		base_up = (QUO_W + 1)'(base_q) + (QUO_W + 1)'(up_off_q);
		mid = {1'b0, avg} + (QUO_W + 1)'(base_q);
		mid_cap = (mid[QUO_W:1] > QUO_W'(LEVEL_MAX)) ? LEVEL_MAX : mid[VAL_W:1];
		rate_mag_new = zero_q ? {1'b0, rmag_q} : prod_q[REC10_SH +: 16];
		rate_neg_new = zero_q ? rneg_q : sgn_q;
		rate_clamped = (rate_mag_new > {1'b0, max_rate_q}) ? max_rate_q
			: rate_mag_new[VAL_W-1:0];
		lvl_d = prod_q[TIME_SH +: VAL_W];
		lvl_up = {1'b0, level_q} + {1'b0, lvl_d};
		base_d = prod_q[REC10_SH +: 12];
		lw = {1'b0, base_q} - {1'b0, lo_off_q};
		uw = {1'b0, base_q} + {1'b0, up_off_q};
		qq = prod_q[REC100_SH +: 16];
		thr = sgn_q ? (18'(lower_q) - 18'(qq)) : (18'(lower_q) + 18'(qq));
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_off_q <= RST_LOWER_OFFSET;
			up_off_q <= RST_UPPER_OFFSET;
			pct_q <= RST_REWARD_PERCENT;
			max_rate_q <= RST_MAX_RATE;
			chk_int_q <= RST_CHECK_INTERVAL;
			auto_q <= 1'b0;
		end else if (cfg_wr.we) begin
			case (cfg_wr.index)
				REG_LOWER_OFFSET:   lo_off_q <= cfg_wr.data[VAL_W-1:0];
				REG_UPPER_OFFSET:   up_off_q <= cfg_wr.data[VAL_W-1:0];
				REG_REWARD_PERCENT: pct_q <= cfg_wr.data[PCT_W-1:0];
				REG_MAX_RATE:       max_rate_q <= cfg_wr.data[VAL_W-1:0];
				REG_CHECK_INTERVAL: chk_int_q <= cfg_wr.data[IVL_W-1:0];
				REG_AUTO_RECAL:     auto_q <= cfg_wr.data[0];
				default:            auto_q <= auto_q;
			endcase
		end
	end

	// tracker state and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			rmag_q <= '0;
			rneg_q <= 1'b0;
			base_q <= '0;
			target_q <= '0;
			tsc_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			avg_due_q <= 1'b0;
			div_cnt_q <= '0;
			event_q <= RECAL_NONE;
		end else if (ctl.fire) begin
			case (ctl.op)
				OP_ACCUM: begin
					event_q <= RECAL_NONE;
					if (acc_ok) begin
						sum_q <= sum_add[SUM_W-1:0];
						cnt_q <= cnt_q + COUNT_WIDTH'(1);
					end
				end
				OP_TIME: begin
					tsc_q <= t_add[IVL_W] ? '1 : t_add[IVL_W-1:0];
				end
				OP_CHECK: begin
					avg_due_q <= expired && session_q;
					if (expired) begin
						tsc_q <= '0;
					end
				end
				OP_DIV_INIT: begin
					div_cnt_q <= '0;
				end
				OP_DIV_STEP: begin
					div_cnt_q <= div_cnt_q + 4'd1;
				end
				OP_RECAL: begin
					sum_q <= '0;
					cnt_q <= '0;
					if (auto_q) begin
						if (avg_lo < (QUO_W + 1)'(base_q)) begin
							target_q <= mid_cap;
							event_q <= RECAL_LOWER;
						end else if ({1'b0, avg} > base_up) begin
							target_q <= mid_cap;
							event_q <= RECAL_RAISE;
						end
					end
				end
				OP_RATE_CLAMP: begin
					rmag_q <= rate_clamped;
					rneg_q <= rate_neg_new;
				end
				OP_LEVEL_UPD: begin
					if (!rneg_q) begin
						level_q <= (lvl_up > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : lvl_up[VAL_W-1:0];
					end else begin
						level_q <= (lvl_d >= level_q) ? '0 : level_q - lvl_d;
					end
				end
				OP_BASE_UPD: begin
					if (sgn_q) begin
						base_q <= base_q - VAL_W'(base_d);
					end else begin
						base_q <= base_q + VAL_W'(base_d);
					end
				end
				default: begin
					avg_due_q <= avg_due_q;
				end
			endcase
		end
	end

	// per-item scratch registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sample_q <= sample;
			elapsed_q <= elapsed;
			session_q <= session_active;
		end
		if (ctl.fire) begin
			case (ctl.op)
				OP_DIV_INIT: begin
					rem_q <= RW'(sum_q[SUM_W-1:QUO_W]);
					dq_q <= sum_q[QUO_W-1:0];
				end
				OP_DIV_STEP: begin
					rem_q <= div_ge ? (div_sh - cnt_ext) : div_sh;
					dq_q <= {dq_q[QUO_W-2:0], div_ge};
				end
				OP_RATE_DIFF: begin
					zero_q <= (sample_q == SAMPLE_W'(level_q));
					if (sample_q > SAMPLE_W'(level_q)) begin
						mag_q <= sample_q - SAMPLE_W'(level_q);
						sgn_q <= 1'b0;
					end else begin
						mag_q <= SAMPLE_W'(level_q) - sample_q;
						sgn_q <= 1'b1;
					end
				end
				OP_BASE_DIST: begin
					if (base_q > target_q) begin
						mag_q <= 16'(base_q - target_q);
						sgn_q <= 1'b1;
					end else begin
						mag_q <= 16'(target_q - base_q);
						sgn_q <= 1'b0;
					end
				end
				OP_BOUNDS: begin
					lower_q <= lw[VAL_W] ? '0 : lw[VAL_W-1:0];
					upper_q <= (uw > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : uw[VAL_W-1:0];
				end
				OP_WIDTH: begin
					if (upper_q >= lower_q) begin
						mag_q <= 16'(upper_q - lower_q);
						sgn_q <= 1'b0;
					end else begin
						mag_q <= 16'(lower_q - upper_q);
						sgn_q <= 1'b1;
					end
				end
				OP_THRESH: begin
					reward_q <= $signed(18'(level_q)) > thr;
				end
				default: begin
					reward_q <= reward_q;
				end
			endcase
		end
	end

	// output register and its valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.fire && ctl.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire && ctl.op == OP_EMIT) begin
			o_level_q <= level_q;
			o_lower_q <= lower_q;
			o_upper_q <= upper_q;
			o_base_q <= base_q;
			o_reward_q <= reward_q;
			o_event_q <= event_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.level = o_level_q;
	assign results.lower_bound = o_lower_q;
	assign results.upper_bound = o_upper_q;
	assign results.baseline = o_base_q;
	assign results.reward = o_reward_q;
	assign results.recalibration = o_event_q;

	// status back to the sequencer
	assign stat.avg_due = avg_due_q;
	assign stat.div_last = &div_cnt_q;
	assign stat.out_free = !out_valid_q || results.ready;

	// level and baseline stay inside 0..100
	assert property (@(posedge clk) disable iff (!arst_n) level_q <= LEVEL_MAX)
		else $error("level above full scale");

	assert property (@(posedge clk) disable iff (!arst_n)
		base_q <= LEVEL_MAX && target_q <= LEVEL_MAX)
		else $error("baseline or target above full scale");

	// rate magnitude is clamped after its step
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.fire && ctl.op == OP_RATE_CLAMP) |=> rmag_q <= $past(max_rate_q))
		else $error("rate not clamped to maximum speed");

	// an emit step always presents a result
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.fire && ctl.op == OP_EMIT) |=> results.valid)
		else $error("result lost at emit");
endmodule

### sv/slew_limited_level_tracker.sv
// ----------------------------------------------------------------------------
// slew_limited_level_tracker
// Slew-limited level tracker with interval averaging and baseline glide.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  samples   in   valid/ready   sample[15:0] elapsed[15:0] session_active
//  results   out  valid/ready   level lower_bound upper_bound baseline
//                               reward recalibration[1:0]
//  cfg       in   valid/ready   index[2:0] data[31:0], ready tied high
//
//  an item runs 19 control steps after its transfer, or 36 when an interval
//  check divides the sum by the count (16 steps of the restoring divider)
//  the next item is taken the cycle after the result is loaded
//  the result register holds one finished item; the last step waits on it
//  arst_n clears state to zero and the registers to their defaults
// ----------------------------------------------------------------------------
module slew_limited_level_tracker #(
	parameter int COUNT_WIDTH = 24
) (
	input logic       clk,
	input logic       arst_n,
	slt_in_if.sink    samples,
	slt_out_if.source results,
	slt_cfg_if.sink   cfg
);
	import slt_pkg::*;

	seq_ctl_t ctl;
	dp_stat_t stat;
	cfg_wr_t  cfg_wr;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;
	assign cfg_wr.we = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data = cfg.data;

	slt_useq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (samples.valid),
		.item_ready (samples.ready),
		.stat       (stat),
		.ctl        (ctl)
	);

	slt_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.cfg_wr         (cfg_wr),
		.sample         (samples.sample),
		.elapsed        (samples.elapsed),
		.session_active (samples.session_active),
		.results        (results)
	);
endmodule

### sim/tb_slew_limited_level_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_slew_limited_level_tracker
// Self-checking bench for the level tracker. A directed table runs first,
// then random samples under several register settings. Every result is
// compared with a cycle-free model of the tracker kept in the bench, or
// with a fixed reading on typed rows; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_slew_limited_level_tracker;
	import slt_pkg::*;

	localparam int     COUNT_W     = 24;
	localparam int     PHASES      = 10;
	localparam int     PHASE_ITEMS = 75;
	localparam int     HOLD_AT     = 400;
	localparam int     LONG_HOLD   = 500;
	localparam int     PAUSE_PHASE = 4;
	localparam int     PAUSE_ITEM  = 30;
	localparam int     END_DRAIN   = 80;
	localparam int     QUIET_LIMIT = 4000;
	localparam longint SUM_TOP     = (64'd1 << SUM_W) - 1;
	localparam longint COUNT_TOP   = (64'd1 << COUNT_W) - 1;
	localparam longint CLOCK_TOP   = 64'hFFFF_FFFF;
	localparam longint GLIDE_DIV   = 10 * 65536;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic [VAL_W-1:0] level;
		logic [VAL_W-1:0] lower_bound;
		logic [VAL_W-1:0] upper_bound;
		logic [VAL_W-1:0] baseline;
		logic             reward;
		logic [REC_W-1:0] recalibration;
	} reading_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [SAMPLE_W-1:0]   sample;
		logic [TIME_W-1:0]     elapsed;
		logic                  session;
		logic                  typed;
		reading_t              want;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} plan_row_t;

	logic clk;
	logic arst_n;

	slt_in_if  samples_if ();
	slt_out_if results_if ();
	slt_cfg_if cfg_if ();

	slew_limited_level_tracker dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	// tracker model state
	logic [15:0]         trk_level;
	logic signed [16:0]  trk_rate;
	logic [15:0]         trk_base;
	logic [15:0]         trk_target;
	logic [31:0]         trk_clock;
	logic [SUM_W-1:0]    trk_sum;
	logic [COUNT_W-1:0]  trk_count;

	// register shadows
	logic [VAL_W-1:0] cfg_lower_off;
	logic [VAL_W-1:0] cfg_upper_off;
	logic [PCT_W-1:0] cfg_pct;
	logic [VAL_W-1:0] cfg_max_rate;
	logic [IVL_W-1:0] cfg_interval;
	logic             cfg_auto;

	reading_t  due_readings[$];
	plan_row_t plan[$];
	logic      fixed_row;
	reading_t  fixed_want;
	bit        sender_calm;
	bit        cfg_open;
	int        errors;
	int        quiet_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// one step of the tracker, returns the reading it causes
	function automatic reading_t next_reading(input logic [SAMPLE_W-1:0] smp,
			input logic [TIME_W-1:0] dt, input logic ses);
		reading_t r;
		longint s, e, sum, cnt, t, avg, b, tg, lv, rt, mr, d;
		longint off_lo, off_hi, lo, hi, pct, thr, top;
		logic [REC_W-1:0] ev;
		s      = smp;
		e      = dt;
		sum    = trk_sum;
		cnt    = trk_count;
		top    = LEVEL_MAX;
		off_lo = cfg_lower_off;
		off_hi = cfg_upper_off;
		ev     = RECAL_NONE;

		// interval accumulators hold once full
		if (cnt < COUNT_TOP && sum + s <= SUM_TOP) begin
			cnt = cnt + 1;
			sum = sum + s;
		end

		// interval time saturates
		t = trk_clock;
		t = t + e;
		if (t > CLOCK_TOP)
			t = CLOCK_TOP;
		trk_clock = t[31:0];

		// interval check, re-centre the target during a session
		if (trk_clock > cfg_interval) begin
			trk_clock = '0;
			if (ses) begin
				avg = (cnt != 0) ? sum / cnt : 0;
				sum = 0;
				cnt = 0;
				b   = trk_base;
				if (cfg_auto) begin
					if (avg < b - off_lo) begin
						tg         = (avg + b) / 2;
						trk_target = (tg > top) ? top[15:0] : tg[15:0];
						ev         = RECAL_LOWER;
					end else if (avg > b + off_hi) begin
						tg         = (avg + b) / 2;
						trk_target = (tg > top) ? top[15:0] : tg[15:0];
						ev         = RECAL_RAISE;
					end
				end
			end
		end
		trk_sum   = sum[SUM_W-1:0];
		trk_count = cnt[COUNT_W-1:0];

		// rate toward the sample, kept when the sample equals the level
		lv = trk_level;
		rt = trk_rate;
		if (s > lv)
			rt = (s - lv) / 10;
		else if (s < lv)
			rt = -((lv - s) / 10);
		mr = cfg_max_rate;
		if (rt > mr)
			rt = mr;
		if (rt < -mr)
			rt = -mr;
		trk_rate = rt[16:0];

		// level update clamped to 0..100
		if (rt >= 0) begin
			d  = (rt * e) / 65536;
			lv = (lv + d > top) ? top : lv + d;
		end else begin
			d  = (-rt * e) / 65536;
			lv = (d >= lv) ? 0 : lv - d;
		end
		trk_level = lv[15:0];

		// baseline glide toward its target
		b  = trk_base;
		tg = trk_target;
		if (b > tg)
			b = b - ((b - tg) * e) / GLIDE_DIV;
		else if (b < tg)
			b = b + ((tg - b) * e) / GLIDE_DIV;
		trk_base = b[15:0];

		// window and reward threshold, signed division
		lo = b - off_lo;
		if (lo < 0)
			lo = 0;
		hi = b + off_hi;
		if (hi > top)
			hi = top;
		pct = cfg_pct;
		thr = lo + ((hi - lo) * pct) / 100;

		r.level         = lv[VAL_W-1:0];
		r.lower_bound   = lo[VAL_W-1:0];
		r.upper_bound   = hi[VAL_W-1:0];
		r.baseline      = b[VAL_W-1:0];
		r.reward        = (lv > thr);
		r.recalibration = ev;
		return r;
	endfunction

	function automatic void plan_item(input logic [SAMPLE_W-1:0] smp,
			input logic [TIME_W-1:0] dt, input logic ses,
			input logic typed = 1'b0, input reading_t want = '0);
		plan_row_t r;
		r         = '0;
		r.kind    = ROW_SAMPLE;
		r.sample  = smp;
		r.elapsed = dt;
		r.session = ses;
		r.typed   = typed;
		r.want    = want;
		plan.push_back(r);
	endfunction

	function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		plan_row_t r;
		r       = '0;
		r.kind  = ROW_WRITE;
		r.index = idx;
		r.data  = value;
		plan.push_back(r);
	endfunction

	task automatic close_writes();
		if (cfg_open)
			cfg_if.valid <= 1'b0;
		cfg_open = 1'b0;
	endtask

	// offer one sample after a random gap, return at the next falling edge
	task automatic offer_sample(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] dt,
			input logic ses, input logic typed, input reading_t want);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 7);
		close_writes();
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_if.valid          <= 1'b1;
		samples_if.sample         <= smp;
		samples_if.elapsed        <= dt;
		samples_if.session_active <= ses;
		fixed_row                 <= typed;
		fixed_want                <= want;
		do @(posedge clk); while (!samples_if.ready);
		@(negedge clk);
	endtask

	// one register write, valid stays up for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_open = 1'b1;
	endtask

	// stop offering and wait until every due reading has come back
	task automatic drain_results();
		close_writes();
		samples_if.valid <= 1'b0;
		do @(negedge clk); while (due_readings.size() != 0);
	endtask

	// register setting for one random phase: extremes first, then the reset values
	task automatic set_registers(input int phase);
		logic [VAL_W-1:0] lo, hi, mr;
		logic [PCT_W-1:0] pct;
		logic [IVL_W-1:0] ivl;
		logic             au;
		case (phase)
			0: begin
				lo  = '0;
				hi  = '0;
				pct = '0;
				mr  = 15'd1;
				ivl = 32'd1;
				au  = 1'b1;
			end
			1: begin
				lo  = LEVEL_MAX;
				hi  = LEVEL_MAX;
				pct = 7'd127;
				mr  = LEVEL_MAX;
				ivl = '1;
				au  = 1'b1;
			end
			2: begin
				lo  = RST_LOWER_OFFSET;
				hi  = RST_UPPER_OFFSET;
				pct = RST_REWARD_PERCENT;
				mr  = RST_MAX_RATE;
				ivl = RST_CHECK_INTERVAL;
				au  = 1'b0;
			end
			default: begin
				lo  = VAL_W'($urandom_range(0, LEVEL_MAX));
				hi  = VAL_W'($urandom_range(0, LEVEL_MAX));
				pct = PCT_W'($urandom_range(0, 127));
				mr  = VAL_W'($urandom_range(0, LEVEL_MAX));
				case ($urandom_range(0, 3))
					0:       ivl = $urandom_range(1, 65535);
					3:       ivl = $urandom_range(1, 32'hFFFF_FFFF);
					default: ivl = $urandom_range(65536, 400000);
				endcase
				au  = ($urandom_range(0, 3) != 0);
			end
		endcase
		drain_results();
		write_reg(REG_LOWER_OFFSET, CFG_DATA_W'(lo));
		write_reg(REG_UPPER_OFFSET, CFG_DATA_W'(hi));
		write_reg(REG_REWARD_PERCENT, CFG_DATA_W'(pct));
		write_reg(REG_MAX_RATE, CFG_DATA_W'(mr));
		write_reg(REG_CHECK_INTERVAL, ivl);
		write_reg(REG_AUTO_RECAL, CFG_DATA_W'(au));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_SPARE, $urandom());
	endtask

	task automatic compare_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			errors++;
		end
	endtask

	// stimulus
	initial begin
		logic [SAMPLE_W-1:0] smp;
		logic [TIME_W-1:0]   dt;

		samples_if.valid          = 1'b0;
		samples_if.sample         = '0;
		samples_if.elapsed        = '0;
		samples_if.session_active = 1'b0;
		cfg_if.valid              = 1'b0;
		cfg_if.index              = '0;
		cfg_if.data               = '0;
		fixed_row                 = 1'b0;
		fixed_want                = '0;
		sender_calm               = 1'b0;
		cfg_open                  = 1'b0;
		errors                    = 0;

		trk_level     = '0;
		trk_rate      = '0;
		trk_base      = '0;
		trk_target    = '0;
		trk_clock     = '0;
		trk_sum       = '0;
		trk_count     = '0;
		cfg_lower_off = RST_LOWER_OFFSET;
		cfg_upper_off = RST_UPPER_OFFSET;
		cfg_pct       = RST_REWARD_PERCENT;
		cfg_max_rate  = RST_MAX_RATE;
		cfg_interval  = RST_CHECK_INTERVAL;
		cfg_auto      = 1'b0;

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// defaults after reset: level at rest, then a full-scale step at the slew limit
		plan_item(16'd0, 16'd0, 1'b0, 1'b1, '{level: 15'd0, lower_bound: 15'd0,
			upper_bound: 15'd2560, baseline: 15'd0, reward: 1'b0, recalibration: RECAL_NONE});
		plan_item(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, '{level: 15'd2559, lower_bound: 15'd0,
			upper_bound: 15'd2560, baseline: 15'd0, reward: 1'b1, recalibration: RECAL_NONE});
		// sample equal to the level keeps the old rate
		plan_item(16'd2559, 16'hFFFF, 1'b0);
		plan_item(16'd0, 16'hFFFF, 1'b0);
		plan_item(16'hFFFF, 16'd0, 1'b1);
		// checks on every sample with re-centring on
		plan_write(REG_MAX_RATE, CFG_DATA_W'(LEVEL_MAX));
		plan_write(REG_CHECK_INTERVAL, 32'd1);
		plan_write(REG_AUTO_RECAL, 32'd1);
		plan_item(16'hFFFF, 16'd2, 1'b1);
		// average far above the window, target capped at full scale
		plan_item(16'hFFFF, 16'hFFFF, 1'b1);
		plan_write(REG_LOWER_OFFSET, 32'd0);
		plan_item(16'd0, 16'hFFFF, 1'b1);
		// expiry outside a session leaves the sum and count growing
		plan_item(16'd30000, 16'd100, 1'b0);
		plan_item(16'd30000, 16'd100, 1'b1);
		// reward percent beyond a full window
		plan_write(REG_UPPER_OFFSET, CFG_DATA_W'(LEVEL_MAX));
		plan_write(REG_REWARD_PERCENT, 32'd127);
		plan_item(16'd20000, 16'hFFFF, 1'b1);
		plan_item(16'd25600, 16'hFFFF, 1'b0);
		plan_write(REG_REWARD_PERCENT, 32'd0);
		plan_item(16'd1, 16'd1, 1'b0);
		// zero slew limit freezes the level
		plan_write(REG_REWARD_PERCENT, 32'd100);
		plan_write(REG_MAX_RATE, 32'd0);
		plan_item(16'hFFFF, 16'hFFFF, 1'b1);
		// unused index is ignored, re-centring off
		plan_write(REG_SPARE, 32'hFFFF_FFFF);
		plan_write(REG_AUTO_RECAL, 32'd0);
		plan_write(REG_CHECK_INTERVAL, 32'hFFFF_FFFF);
		plan_item(16'd0, 16'hFFFF, 1'b1);
		plan_item(16'd12345, 16'hFFFF, 1'b1);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				drain_results();
				write_reg(plan[i].index, plan[i].data);
			end else begin
				offer_sample(plan[i].sample, plan[i].elapsed, plan[i].session,
					plan[i].typed, plan[i].want);
			end
		end

		// random phases
		for (int p = 0; p < PHASES; p++) begin
			set_registers(p);
			sender_calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == PAUSE_PHASE && k == PAUSE_ITEM)
					drain_results();
				case ($urandom_range(0, 9))
					0:       smp = '0;
					1:       smp = '1;
					2:       smp = trk_level;
					3, 4:    smp = SAMPLE_W'($urandom_range(0, 65535));
					default: smp = SAMPLE_W'($urandom_range(0, LEVEL_MAX));
				endcase
				case ($urandom_range(0, 7))
					0:       dt = '0;
					1:       dt = '1;
					2:       dt = TIME_W'($urandom_range(0, 255));
					default: dt = TIME_W'($urandom_range(0, 65535));
				endcase
				offer_sample(smp, dt, ($urandom_range(0, 4) != 0), 1'b0, '0);
			end
		end

		drain_results();
		repeat (END_DRAIN) @(posedge clk);
		if (due_readings.size() != 0) begin
			$display("%0t: %0d readings never arrived", $time, due_readings.size());
			errors++;
		end
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// result side: random stalls, one long hold-off, calm stretches
	initial begin : receiver
		int stall;
		int taken;
		bit calm;
		taken = 0;
		calm  = 1'b0;
		results_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (taken == HOLD_AT)
				stall = LONG_HOLD;
			else
				stall = calm ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				results_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			results_if.ready <= 1'b1;
			do @(posedge clk); while (!results_if.valid);
			@(negedge clk);
			taken++;
		end
	end

	// transfer monitor: predict on sample transfers, check on result transfers, shadow register writes
	always @(posedge clk) begin : monitor
		reading_t got;
		reading_t want;
		if (arst_n) begin
			if (results_if.valid && results_if.ready) begin
				got = '{level: results_if.level, lower_bound: results_if.lower_bound,
					upper_bound: results_if.upper_bound, baseline: results_if.baseline,
					reward: results_if.reward, recalibration: results_if.recalibration};
				if (due_readings.size() == 0) begin
					$display("%0t: reading with none due, got level %0d baseline %0d",
						$time, got.level, got.baseline);
					errors++;
				end else begin
					want = due_readings.pop_front();
					compare_field("level", 32'(want.level), 32'(got.level));
					compare_field("lower_bound", 32'(want.lower_bound), 32'(got.lower_bound));
					compare_field("upper_bound", 32'(want.upper_bound), 32'(got.upper_bound));
					compare_field("baseline", 32'(want.baseline), 32'(got.baseline));
					compare_field("reward", 32'(want.reward), 32'(got.reward));
					compare_field("recalibration", 32'(want.recalibration),
						32'(got.recalibration));
				end
			end
			if (samples_if.valid && samples_if.ready) begin
				want = next_reading(samples_if.sample, samples_if.elapsed,
					samples_if.session_active);
				due_readings.push_back(fixed_row ? fixed_want : want);
			end
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.index)
					REG_LOWER_OFFSET:   cfg_lower_off = cfg_if.data[VAL_W-1:0];
					REG_UPPER_OFFSET:   cfg_upper_off = cfg_if.data[VAL_W-1:0];
					REG_REWARD_PERCENT: cfg_pct       = cfg_if.data[PCT_W-1:0];
					REG_MAX_RATE:       cfg_max_rate  = cfg_if.data[VAL_W-1:0];
					REG_CHECK_INTERVAL: cfg_interval  = cfg_if.data[IVL_W-1:0];
					REG_AUTO_RECAL:     cfg_auto      = cfg_if.data[0];
					default: ;
				endcase
			end
		end
	end

	// watchdog on cycles without any transfer
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule
